@@ rtl/brb_pkg.sv @@
// shared constants and types for the byte ring buffer
`timescale 1ns / 1ps
package brb_pkg;

  localparam int STORE_DEPTH = 2048;
  localparam int MAX_BURST   = 64;

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int CNT_W = $clog2(MAX_BURST + 1);

  // fixed widths of the request and result fields
  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int RCOUNT_W = 7;
  localparam int OFFSET_W = 11;
  localparam int AMOUNT_W = 12;
  localparam int LEVEL_W  = 12;

  // compare width that holds the pointer span and every request field
  localparam int CMP_W = (PTR_W > AMOUNT_W) ? PTR_W : AMOUNT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH    = 2'd0,
    KIND_READ    = 2'd1,
    KIND_PEEK    = 2'd2,
    KIND_CONSUME = 2'd3
  } brb_kind_e;

  typedef struct packed {
    logic      start;
    brb_kind_e kind;
    logic      deliver;
    logic      fetch_next;
  } brb_cmd_t;

  typedef struct packed {
    logic out_free;
    logic peek_ok;
    logic burst_nz;
    logic last_byte;
  } brb_sts_t;

endpackage

@@ rtl/brb_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/brb_ctrl.sv @@
// request sequencer for the byte ring buffer
`timescale 1ns / 1ps
module brb_ctrl import brb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  brb_kind_e kind_i,
  input  brb_sts_t  sts_i,
  output brb_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_DATA
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    in_stall_o        = !((state_q == S_IDLE) && sts_i.out_free);
    cmd_o.start       = 1'b0;
    cmd_o.kind        = kind_i;
    cmd_o.deliver     = 1'b0;
    cmd_o.fetch_next  = 1'b0;
    state_d           = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.start = 1'b1;
          if (((kind_i == KIND_READ) && sts_i.burst_nz) ||
              ((kind_i == KIND_PEEK) && sts_i.peek_ok)) begin
            state_d = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (sts_i.out_free) begin
          cmd_o.deliver = 1'b1;
          if (sts_i.last_byte) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.fetch_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> in_stall_o)
    else $error("request taken while a read is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.deliver && sts_i.last_byte) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after final byte");

endmodule

@@ rtl/brb_dp.sv @@
// pointers, byte store and result register of the byte ring buffer
`timescale 1ns / 1ps
module brb_dp import brb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brb_cmd_t            cmd_i,
  output brb_sts_t            sts_o,
  input  logic [BYTE_W-1:0]   rx_byte_i,
  input  logic [RCOUNT_W-1:0] read_count_i,
  input  logic [OFFSET_W-1:0] peek_offset_i,
  input  logic [AMOUNT_W-1:0] consume_amount_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic                byte_valid_o,
  output logic                dropped_o,
  output logic [LEVEL_W-1:0]  fill_level_o,
  output logic                last_o
);

  logic [PTR_W-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              byte_valid_q, byte_valid_d;
  logic              dropped_q, dropped_d;
  logic [PTR_W-1:0]  level_q, level_d;
  logic              last_q, last_d;

  logic [PTR_W-1:0]  fill;
  logic [CMP_W-1:0]  fill_x, amt_x, cnt_x, burst_x, take_x;
  logic              full;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign fill   = wp_q - rp_q;
  assign fill_x = CMP_W'(fill);
  assign amt_x  = CMP_W'(consume_amount_i);
  assign full   = (fill_x >= CMP_W'(STORE_DEPTH));

  // burst length: request count capped by burst limit and fill level
  always_comb begin
    cnt_x = CMP_W'(read_count_i);
    if (cnt_x > CMP_W'(MAX_BURST)) begin
      cnt_x = CMP_W'(MAX_BURST);
    end
    burst_x = (cnt_x > fill_x) ? fill_x : cnt_x;
    take_x  = (amt_x > fill_x) ? fill_x : amt_x;
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.peek_ok   = (CMP_W'(peek_offset_i) < fill_x);
  assign sts_o.burst_nz  = (burst_x != '0);
  assign sts_o.last_byte = (cnt_q == CNT_W'(1));

  always_comb begin
    rp_d         = rp_q;
    wp_d         = wp_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    dropped_d    = dropped_q;
    level_d      = level_q;
    last_d       = last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = rp_q[IDX_W-1:0];

    if (cmd_i.start) begin
      // immediate result, overridden below when a store read is issued
      out_valid_d  = 1'b1;
      out_byte_d   = '0;
      byte_valid_d = 1'b0;
      dropped_d    = 1'b0;
      level_d      = fill;
      last_d       = 1'b1;
      case (cmd_i.kind)
        KIND_PUSH: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            ram_we  = 1'b1;
            wp_d    = wp_q + PTR_W'(1);
            level_d = fill + PTR_W'(1);
          end
        end
        KIND_READ: begin
          if (sts_o.burst_nz) begin
            out_valid_d = 1'b0;
            ram_re      = 1'b1;
            rp_d        = rp_q + PTR_W'(1);
            cnt_d       = CNT_W'(burst_x);
          end
        end
        KIND_PEEK: begin
          if (sts_o.peek_ok) begin
            out_valid_d = 1'b0;
            ram_re      = 1'b1;
            ram_raddr   = rp_q[IDX_W-1:0] + IDX_W'(peek_offset_i);
            cnt_d       = CNT_W'(1);
          end
        end
        KIND_CONSUME: begin
          rp_d    = rp_q + PTR_W'(take_x);
          level_d = fill - PTR_W'(take_x);
        end
        default: begin
          out_valid_d = 1'b1;
        end
      endcase
    end

    if (cmd_i.deliver) begin
      out_valid_d  = 1'b1;
      out_byte_d   = ram_rdata;
      byte_valid_d = 1'b1;
      dropped_d    = 1'b0;
      level_d      = fill;
      last_d       = sts_o.last_byte;
      cnt_d        = cnt_q - CNT_W'(1);
    end

    if (cmd_i.fetch_next) begin
      ram_re = 1'b1;
      rp_d   = rp_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    dropped_q    <= dropped_d;
    level_q      <= level_d;
    last_q       <= last_d;
  end

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q[IDX_W-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign dropped_o    = dropped_q;
  assign fill_level_o = LEVEL_W'(level_q);
  assign last_o       = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_x <= CMP_W'(STORE_DEPTH))
    else $error("fill level beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deliver |-> (cnt_q != '0))
    else $error("byte delivered with no byte pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start || cmd_i.deliver) |-> sts_o.out_free)
    else $error("result register overwritten while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.deliver && sts_o.last_byte) |=> (cnt_q == '0))
    else $error("byte count not cleared after final byte");

endmodule

@@ rtl/byte_ring_buffer_peek_consume.sv @@
// top level of the byte ring buffer with peek and consume
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o kind, rx_byte, read_count,
//                                               peek_offset, consume_amount
//   out      output     out_valid_o/out_stall_i out_byte, byte_valid, dropped,
//                                               fill_level, last
//
// push, consume and failed peek or empty read: result next cycle
// peek: one store read; read burst: one byte per cycle while the output is not
// stalled, each byte fetched through the registered read port of the byte store
// a new request is taken once the previous one has loaded its final result
// output stall holds the result register and pauses the burst
// reset clears pointers, count and result valid; the store is not cleared
`timescale 1ns / 1ps
module byte_ring_buffer_peek_consume import brb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [BYTE_W-1:0]   rx_byte_i,
  input  logic [RCOUNT_W-1:0] read_count_i,
  input  logic [OFFSET_W-1:0] peek_offset_i,
  input  logic [AMOUNT_W-1:0] consume_amount_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic                byte_valid_o,
  output logic                dropped_o,
  output logic [LEVEL_W-1:0]  fill_level_o,
  output logic                last_o
);

  brb_cmd_t cmd;
  brb_sts_t sts;

  brb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (brb_kind_e'(kind_i)),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rx_byte_i        (rx_byte_i),
    .read_count_i     (read_count_i),
    .peek_offset_i    (peek_offset_i),
    .consume_amount_i (consume_amount_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .dropped_o        (dropped_o),
    .fill_level_o     (fill_level_o),
    .last_o           (last_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the byte ring buffer: push, read burst, peek and consume checks
`timescale 1ns / 1ps
module tb_top;
  import brb_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               dropped;
    logic [LEVEL_W-1:0] fill_level;
    logic               is_last;
  } ring_result_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i = '0;
  logic [BYTE_W-1:0]   rx_byte_i = '0;
  logic [RCOUNT_W-1:0] read_count_i = '0;
  logic [OFFSET_W-1:0] peek_offset_i = '0;
  logic [AMOUNT_W-1:0] consume_amount_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [BYTE_W-1:0]   out_byte_o;
  logic                byte_valid_o;
  logic                dropped_o;
  logic [LEVEL_W-1:0]  fill_level_o;
  logic                last_o;

  // ring model state
  logic [BYTE_W-1:0] ring_mem [STORE_DEPTH];
  logic [PTR_W-1:0]  rd_ptr = '0;
  logic [PTR_W-1:0]  wr_ptr = '0;
  ring_result_t      due_results [$];

  int          mismatch_count = 0;
  bit          pace_on = 1'b0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  logic [31:0] stall_bits = '0;
  int unsigned stall_age = 0;

  byte_ring_buffer_peek_consume u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .rx_byte_i        (rx_byte_i),
    .read_count_i     (read_count_i),
    .peek_offset_i    (peek_offset_i),
    .consume_amount_i (consume_amount_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .dropped_o        (dropped_o),
    .fill_level_o     (fill_level_o),
    .last_o           (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #(50_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [PTR_W-1:0] ring_level();
    return wr_ptr - rd_ptr;
  endfunction

  task automatic queue_result(input logic [BYTE_W-1:0] data, input logic valid,
                              input logic drop, input logic fin);
    ring_result_t r;
    r.out_byte   = data;
    r.byte_valid = valid;
    r.dropped    = drop;
    r.fill_level = LEVEL_W'(ring_level());
    r.is_last    = fin;
    due_results.push_back(r);
  endtask

  task automatic compute_ring_results(input brb_kind_e kind, input logic [BYTE_W-1:0] rx,
                                      input logic [RCOUNT_W-1:0] cnt,
                                      input logic [OFFSET_W-1:0] off,
                                      input logic [AMOUNT_W-1:0] amt);
    logic [PTR_W-1:0]  level;
    logic [PTR_W-1:0]  peek_ptr;
    logic [BYTE_W-1:0] b;
    int unsigned       n;
    int unsigned       i;
    level = ring_level();
    case (kind)
      KIND_PUSH: begin
        if (level < STORE_DEPTH) begin
          ring_mem[wr_ptr[IDX_W-1:0]] = rx;
          wr_ptr = wr_ptr + 1'b1;
          queue_result('0, 1'b0, 1'b0, 1'b1);
        end else begin
          queue_result('0, 1'b0, 1'b1, 1'b1);
        end
      end
      KIND_READ: begin
        n = (cnt > MAX_BURST) ? MAX_BURST : cnt;
        if (n > level) n = level;
        if (n == 0) queue_result('0, 1'b0, 1'b0, 1'b1);
        for (i = 0; i < n; i++) begin
          b = ring_mem[rd_ptr[IDX_W-1:0]];
          rd_ptr = rd_ptr + 1'b1;
          queue_result(b, 1'b1, 1'b0, i + 1 == n);
        end
      end
      KIND_PEEK: begin
        if (PTR_W'(off) < level) begin
          peek_ptr = rd_ptr + PTR_W'(off);
          queue_result(ring_mem[peek_ptr[IDX_W-1:0]], 1'b1, 1'b0, 1'b1);
        end else begin
          queue_result('0, 1'b0, 1'b0, 1'b1);
        end
      end
      default: begin
        rd_ptr = rd_ptr + ((amt > level) ? level : PTR_W'(amt));
        queue_result('0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic send_request(input brb_kind_e kind, input logic [BYTE_W-1:0] rx,
                              input logic [RCOUNT_W-1:0] cnt,
                              input logic [OFFSET_W-1:0] off,
                              input logic [AMOUNT_W-1:0] amt);
    int unsigned gap;
    if (pace_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                 : $urandom_range(1, 6);
      end
      burst_left--;
    end
    @(negedge clk_i);
    in_valid_i       = 1'b1;
    kind_i           = kind;
    rx_byte_i        = rx;
    read_count_i     = cnt;
    peek_offset_i    = off;
    consume_amount_i = amt;
    do @(posedge clk_i); while (in_stall_o);
    compute_ring_results(kind, rx, cnt, off, amt);
  endtask

  task automatic push_byte(input int unsigned b);
    send_request(KIND_PUSH, BYTE_W'(b), RCOUNT_W'($urandom), OFFSET_W'($urandom),
                 AMOUNT_W'($urandom));
  endtask

  task automatic read_burst(input int unsigned cnt);
    send_request(KIND_READ, BYTE_W'($urandom), RCOUNT_W'(cnt), OFFSET_W'($urandom),
                 AMOUNT_W'($urandom));
  endtask

  task automatic peek_at(input int unsigned off);
    send_request(KIND_PEEK, BYTE_W'($urandom), RCOUNT_W'($urandom), OFFSET_W'(off),
                 AMOUNT_W'($urandom));
  endtask

  task automatic consume_bytes(input int unsigned amt);
    send_request(KIND_CONSUME, BYTE_W'($urandom), RCOUNT_W'($urandom),
                 OFFSET_W'($urandom), AMOUNT_W'(amt));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall pattern from a rotating word that is redrawn when its age counter wraps, with optional long hold
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[31:1]};
      if (stall_age == 63) begin
        stall_age = 0;
        case ($urandom_range(0, 3))
          0: stall_bits = '0;
          1: stall_bits = $urandom & $urandom & $urandom;
          2: stall_bits = $urandom;
          default: stall_bits = $urandom | $urandom;
        endcase
      end else begin
        stall_age++;
      end
    end
  end

  task automatic check_field(input string name, input logic [LEVEL_W-1:0] want,
                             input logic [LEVEL_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ring_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing pending, expected none actual byte %0h level %0h",
                 $time, out_byte_o, fill_level_o);
      end else begin
        want = due_results.pop_front();
        check_field("out_byte", LEVEL_W'(want.out_byte), LEVEL_W'(out_byte_o));
        check_field("byte_valid", LEVEL_W'(want.byte_valid), LEVEL_W'(byte_valid_o));
        check_field("dropped", LEVEL_W'(want.dropped), LEVEL_W'(dropped_o));
        check_field("fill_level", want.fill_level, fill_level_o);
        check_field("last", LEVEL_W'(want.is_last), LEVEL_W'(last_o));
      end
    end
  end

  task automatic test_empty_store();
    read_burst(0);
    read_burst(MAX_BURST);
    peek_at(0);
    consume_bytes(0);
    consume_bytes(STORE_DEPTH);
    wait_drained();
  endtask

  task automatic test_push_peek_read();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);
    peek_at(0);
    peek_at(3);
    peek_at(4);
    peek_at(STORE_DEPTH - 1);
    read_burst(0);
    read_burst(2);
    consume_bytes(1);
    read_burst(127);
    read_burst(1);
    consume_bytes(STORE_DEPTH);
    wait_drained();
  endtask

  task automatic test_burst_limit();
    repeat (70) push_byte($urandom_range(0, 255));
    read_burst(127);
    read_burst(MAX_BURST);
    repeat (3) push_byte($urandom_range(0, 255));
    read_burst(3);
    consume_bytes(0);
    read_burst(0);
    wait_drained();
  endtask

  task automatic test_full_store();
    while (ring_level() < STORE_DEPTH) push_byte($urandom_range(0, 255));
    repeat (3) push_byte($urandom_range(0, 255));
    peek_at(STORE_DEPTH - 1);
    peek_at(0);
    read_burst(127);
    peek_at(STORE_DEPTH - 1);
    consume_bytes(4095);
    peek_at(0);
    read_burst(MAX_BURST);
    wait_drained();
  endtask

  task automatic test_backpressure();
    @(posedge clk_i);
    hold_left = 300;
    repeat (20) push_byte($urandom_range(0, 255));
    read_burst(30);
    peek_at(2);
    consume_bytes(3);
    repeat (5) push_byte($urandom_range(0, 255));
    wait_drained();
    consume_bytes(STORE_DEPTH);
    wait_drained();
  endtask

  task automatic test_random_mix();
    int unsigned sel;
    int unsigned level;
    pace_on = 1'b1;
    repeat (110) begin
      sel = $urandom_range(0, 99);
      level = ring_level();
      if (sel < 45) begin
        push_byte($urandom_range(0, 255));
      end else if (sel < 65) begin
        read_burst(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(1, 8));
      end else if (sel < 85) begin
        if (level > 0 && $urandom_range(0, 3) != 0) peek_at($urandom_range(0, level - 1));
        else peek_at($urandom_range(0, STORE_DEPTH - 1));
      end else begin
        case ($urandom_range(0, 3))
          0: consume_bytes($urandom_range(0, 4095));
          1: consume_bytes(level + $urandom_range(0, 5));
          default: consume_bytes($urandom_range(0, 4));
        endcase
      end
    end
    pace_on = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_store();
    test_push_peek_read();
    test_burst_limit();
    test_full_store();
    test_backpressure();
    test_random_mix();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
